@@ rtl/pic_pkg.sv @@
// Shared types, codes and helpers for the interrupt controller.
`default_nettype none
package pic_pkg;

  localparam int NUM_LINES = 8;
  localparam int LVL_W     = $clog2(NUM_LINES + 1);
  localparam int IDX_W     = $clog2(NUM_LINES);

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_ACK    = 2'd3
  } kind_t;

  // Command word decode
  localparam logic [7:0] ICW1_FLAG   = 8'h10;
  localparam logic [7:0] OCW3_FLAG   = 8'h08;
  localparam logic [7:0] RR_FLAG     = 8'h02;
  localparam logic [7:0] RIS_FLAG    = 8'h01;
  localparam logic [7:0] IC4_FLAG    = 8'h01;
  localparam logic [7:0] MASK_RESET  = 8'hFF;
  localparam logic [7:0] LINES_HIGH  = 8'hFF;

  localparam logic [2:0] EOI_NONSPEC = 3'b001;
  localparam logic [2:0] EOI_SPEC    = 3'b011;

  localparam logic [2:0] SPURIOUS_LVL = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic       port_sel;
    logic [7:0] wdata;
    logic [7:0] irq_lines;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       int_out;
    logic [7:0] vector;
    logic       spurious;
  } out_item_t;

  // Index of the lowest set bit (highest priority), NUM_LINES if none.
  function automatic logic [LVL_W-1:0] top_level(input logic [NUM_LINES-1:0] bits);
    logic [LVL_W-1:0] lv;
    lv = LVL_W'(NUM_LINES);
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (bits[i]) begin
        lv = LVL_W'(i);
      end
    end
    return lv;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pic_if.sv @@
// Valid/ready channel interfaces for bus items and results.
`default_nettype none
interface pic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       port_sel;
  logic [7:0] wdata;
  logic [7:0] irq_lines;

  modport source (output valid, kind, port_sel, wdata, irq_lines, input ready);
  modport sink   (input valid, kind, port_sel, wdata, irq_lines, output ready);
endinterface

interface pic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       int_out;
  logic [7:0] vector;
  logic       spurious;

  modport source (output valid, rdata, int_out, vector, spurious, input ready);
  modport sink   (input valid, rdata, int_out, vector, spurious, output ready);
endinterface
`default_nettype wire

@@ rtl/pic_core.sv @@
// Controller state: init sequence, mask, IRR/ISR and the per-item result logic.
`default_nettype none
module pic_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire pic_pkg::in_item_t  item,
  output pic_pkg::out_item_t      result
);

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_ICW2  = 2'd1,
    PH_ICW3  = 2'd2,
    PH_ICW4  = 2'd3
  } phase_t;

  phase_t      init_phase, init_phase_next;
  logic        need_icw4, need_icw4_next;
  logic        level_mode, level_mode_next;
  logic [4:0]  vector_base, vector_base_next;
  logic [7:0]  cascade_word, cascade_word_next;
  logic [7:0]  mask_reg, mask_reg_next;
  logic [7:0]  request_reg, request_reg_next;
  logic [7:0]  service_reg, service_reg_next;
  logic        read_service_sel, read_service_sel_next;
  logic [7:0]  prev_lines, prev_lines_next;

  logic [pic_pkg::LVL_W-1:0] win_lv, svc_lv, req_lv;
  logic [pic_pkg::LVL_W-1:0] new_req_lv, new_svc_lv;
  logic [7:0]                d;

  assign d = item.wdata;

  always_comb begin
    req_lv = pic_pkg::top_level(request_reg & ~mask_reg);
    svc_lv = pic_pkg::top_level(service_reg);
    win_lv = (req_lv < svc_lv) ? req_lv : pic_pkg::LVL_W'(pic_pkg::NUM_LINES);
  end

  always_comb begin
    init_phase_next       = init_phase;
    need_icw4_next        = need_icw4;
    level_mode_next       = level_mode;
    vector_base_next      = vector_base;
    cascade_word_next     = cascade_word;
    mask_reg_next         = mask_reg;
    request_reg_next      = request_reg;
    service_reg_next      = service_reg;
    read_service_sel_next = read_service_sel;
    prev_lines_next       = prev_lines;
    result.rdata          = '0;
    result.vector         = '0;
    result.spurious       = 1'b0;

    unique case (pic_pkg::kind_t'(item.kind))
      pic_pkg::KIND_WRITE: begin
        if (!item.port_sel) begin
          if ((d & pic_pkg::ICW1_FLAG) != '0) begin
            init_phase_next       = PH_ICW2;
            need_icw4_next        = (d & pic_pkg::IC4_FLAG) != '0;
            level_mode_next       = d[3];
            mask_reg_next         = '0;
            request_reg_next      = '0;
            service_reg_next      = '0;
            read_service_sel_next = 1'b0;
            // lines already high must see a fresh rising edge
            prev_lines_next       = pic_pkg::LINES_HIGH;
          end else if (init_phase != PH_READY) begin
            // command writes ignored mid-initialization
          end else if ((d & pic_pkg::OCW3_FLAG) != '0) begin
            if ((d & pic_pkg::RR_FLAG) != '0) begin
              read_service_sel_next = (d & pic_pkg::RIS_FLAG) != '0;
            end
          end else if (d[7:5] == pic_pkg::EOI_NONSPEC) begin
            if (svc_lv < pic_pkg::LVL_W'(pic_pkg::NUM_LINES)) begin
              service_reg_next = service_reg & ~(8'd1 << svc_lv[pic_pkg::IDX_W-1:0]);
            end
          end else if (d[7:5] == pic_pkg::EOI_SPEC) begin
            service_reg_next = service_reg & ~(8'd1 << d[2:0]);
          end
        end else begin
          unique case (init_phase)
            PH_ICW2: begin
              vector_base_next = d[7:3];
              init_phase_next  = PH_ICW3;
            end
            PH_ICW3: begin
              cascade_word_next = d;
              init_phase_next   = need_icw4 ? PH_ICW4 : PH_READY;
            end
            PH_ICW4: init_phase_next = PH_READY;
            PH_READY: mask_reg_next = d;
          endcase
        end
      end
      pic_pkg::KIND_READ: begin
        if (item.port_sel) begin
          result.rdata = mask_reg;
        end else begin
          result.rdata = read_service_sel ? service_reg : request_reg;
        end
      end
      pic_pkg::KIND_SAMPLE: begin
        if (level_mode) begin
          request_reg_next = item.irq_lines;
        end else begin
          request_reg_next = (request_reg | (item.irq_lines & ~prev_lines)) & item.irq_lines;
        end
        prev_lines_next = item.irq_lines;
      end
      pic_pkg::KIND_ACK: begin
        if (win_lv < pic_pkg::LVL_W'(pic_pkg::NUM_LINES)) begin
          request_reg_next = request_reg & ~(8'd1 << win_lv[pic_pkg::IDX_W-1:0]);
          service_reg_next = service_reg | (8'd1 << win_lv[pic_pkg::IDX_W-1:0]);
          result.vector    = {vector_base, win_lv[pic_pkg::IDX_W-1:0]};
        end else begin
          result.vector    = {vector_base, pic_pkg::SPURIOUS_LVL};
          result.spurious  = 1'b1;
        end
      end
    endcase

    // int_out reflects the state after this item
    new_req_lv     = pic_pkg::top_level(request_reg_next & ~mask_reg_next);
    new_svc_lv     = pic_pkg::top_level(service_reg_next);
    result.int_out = new_req_lv < new_svc_lv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_phase       <= PH_READY;
      need_icw4        <= 1'b0;
      level_mode       <= 1'b0;
      vector_base      <= '0;
      cascade_word     <= '0;
      mask_reg         <= pic_pkg::MASK_RESET;
      request_reg      <= '0;
      service_reg      <= '0;
      read_service_sel <= 1'b0;
      prev_lines       <= '0;
    end else if (en) begin
      init_phase       <= init_phase_next;
      need_icw4        <= need_icw4_next;
      level_mode       <= level_mode_next;
      vector_base      <= vector_base_next;
      cascade_word     <= cascade_word_next;
      mask_reg         <= mask_reg_next;
      request_reg      <= request_reg_next;
      service_reg      <= service_reg_next;
      read_service_sel <= read_service_sel_next;
      prev_lines       <= prev_lines_next;
    end
  end

  a_reset_mask: assert property (@(posedge clk) rst |=> mask_reg == pic_pkg::MASK_RESET)
    else $error("mask not all-ones after reset");

  // an acknowledge puts at most one level in service
  a_one_new_isr: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(service_reg & ~$past(service_reg)) <= 1)
    else $error("more than one ISR bit set in one cycle");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(service_reg) && $stable(request_reg) && $stable(mask_reg))
    else $error("state changed without a processed item");

endmodule
`default_nettype wire

@@ rtl/programmable_interrupt_controller.sv @@
// An accepted item sits in the input reg, then its result in the result reg.
// Throughput: one item per cycle unless stalled; the priority encoders sit between the two registers.
// Ready drops only while both registers hold items and the result is not taken.
// Reset (rst, synchronous): controller ready, all lines masked, IRR/ISR clear,
// pipeline empty.
`default_nettype none
module programmable_interrupt_controller (
  input wire logic  clk,
  input wire logic  rst,
  pic_in_if.sink    req,
  pic_out_if.source rsp
);

  pic_pkg::in_item_t  s1_item;
  logic               s1_valid;
  pic_pkg::out_item_t core_result;
  pic_pkg::out_item_t out_item;
  logic               out_valid;
  logic               advance;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  pic_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_valid && advance),
    .item   (s1_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= '{kind: req.kind, port_sel: req.port_sel, wdata: req.wdata,
                   irq_lines: req.irq_lines};
    end
    if (s1_valid && advance) begin
      out_item <= core_result;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.rdata    = out_item.rdata;
  assign rsp.int_out  = out_item.int_out;
  assign rsp.vector   = out_item.vector;
  assign rsp.spurious = out_item.spurious;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input stage overwritten while stalled");

  a_spur_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.spurious |-> out_item.vector[2:0] == pic_pkg::SPURIOUS_LVL)
    else $error("spurious result without level-7 vector");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid)
    else $error("processed item did not reach the result register");

endmodule
`default_nettype wire

@@ tb/sv/tb_programmable_interrupt_controller.sv @@
// Self-checking testbench for the 8259A-style interrupt controller.
`timescale 1ns / 100ps
module tb_programmable_interrupt_controller;

  localparam logic [7:0] LTIM_BIT = 8'h08;
  localparam int HALF_PERIOD = 2;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_ICW2  = 2'd1,
    ST_ICW3  = 2'd2,
    ST_ICW4  = 2'd3
  } init_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pic_in_if  in_ch ();
  pic_out_if out_ch ();

  programmable_interrupt_controller u_top (
    .clk(clk),
    .rst(rst),
    .req(in_ch),
    .rsp(out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predicted controller state
  init_step_t init_step   = ST_READY;
  logic       icw4_wanted = 1'b0;
  logic       level_trig  = 1'b0;
  logic [4:0] vec_base    = '0;
  logic [7:0] cascade     = '0;
  logic [7:0] imr         = pic_pkg::MASK_RESET;
  logic [7:0] irr         = '0;
  logic [7:0] isr         = '0;
  logic       read_isr    = 1'b0;
  logic [7:0] last_lines  = '0;

  pic_pkg::out_item_t pending_q[$];
  int         errors     = 0;
  int         sent_count = 0;
  bit         idle_on    = 1'b1;
  logic [7:0] line_drive = '0;

  function automatic logic [3:0] lowest_set(input logic [7:0] bits);
    for (int i = 0; i < pic_pkg::NUM_LINES; i++) begin
      if (bits[i]) begin
        return 4'(i);
      end
    end
    return 4'(pic_pkg::NUM_LINES);
  endfunction

  // Unmasked request that outranks everything in service, NUM_LINES if none.
  function automatic logic [3:0] grant_level();
    logic [3:0] req_lv;
    logic [3:0] svc_lv;
    req_lv = lowest_set(irr & ~imr);
    svc_lv = lowest_set(isr);
    return (req_lv < svc_lv) ? req_lv : 4'(pic_pkg::NUM_LINES);
  endfunction

  task automatic predict_item(input pic_pkg::in_item_t it, output pic_pkg::out_item_t res);
    logic [3:0] lv;
    res = '0;
    case (pic_pkg::kind_t'(it.kind))
      pic_pkg::KIND_WRITE: begin
        if (!it.port_sel) begin
          if ((it.wdata & pic_pkg::ICW1_FLAG) != 0) begin
            init_step   = ST_ICW2;
            icw4_wanted = (it.wdata & pic_pkg::IC4_FLAG) != 0;
            level_trig  = (it.wdata & LTIM_BIT) != 0;
            imr         = '0;
            irr         = '0;
            isr         = '0;
            read_isr    = 1'b0;
            last_lines  = pic_pkg::LINES_HIGH;
          end else if (init_step != ST_READY) begin
            // command words dropped mid-initialization
          end else if ((it.wdata & pic_pkg::OCW3_FLAG) != 0) begin
            if ((it.wdata & pic_pkg::RR_FLAG) != 0) begin
              read_isr = (it.wdata & pic_pkg::RIS_FLAG) != 0;
            end
          end else if (it.wdata[7:5] == pic_pkg::EOI_NONSPEC) begin
            lv = lowest_set(isr);
            if (lv < pic_pkg::NUM_LINES) begin
              isr[lv[2:0]] = 1'b0;
            end
          end else if (it.wdata[7:5] == pic_pkg::EOI_SPEC) begin
            isr[it.wdata[2:0]] = 1'b0;
          end
        end else begin
          case (init_step)
            ST_ICW2: begin
              vec_base  = it.wdata[7:3];
              init_step = ST_ICW3;
            end
            ST_ICW3: begin
              cascade   = it.wdata;
              init_step = icw4_wanted ? ST_ICW4 : ST_READY;
            end
            ST_ICW4: init_step = ST_READY;
            default: imr = it.wdata;
          endcase
        end
      end
      pic_pkg::KIND_READ: begin
        res.rdata = it.port_sel ? imr : (read_isr ? isr : irr);
      end
      pic_pkg::KIND_SAMPLE: begin
        if (level_trig) begin
          irr = it.irq_lines;
        end else begin
          irr = (irr | (it.irq_lines & ~last_lines)) & it.irq_lines;
        end
        last_lines = it.irq_lines;
      end
      default: begin
        lv = grant_level();
        if (lv < pic_pkg::NUM_LINES) begin
          irr[lv[2:0]] = 1'b0;
          isr[lv[2:0]] = 1'b1;
          res.vector   = {vec_base, lv[2:0]};
        end else begin
          res.vector   = {vec_base, pic_pkg::SPURIOUS_LVL};
          res.spurious = 1'b1;
        end
      end
    endcase
    res.int_out = grant_level() < pic_pkg::NUM_LINES;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input pic_pkg::kind_t k, input logic p, input logic [7:0] d,
                           input logic [7:0] l);
    pic_pkg::in_item_t  it;
    pic_pkg::out_item_t res;
    int                 gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.port_sel  <= p;
    in_ch.wdata     <= d;
    in_ch.irq_lines <= l;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    it.kind      = k;
    it.port_sel  = p;
    it.wdata     = d;
    it.irq_lines = l;
    predict_item(it, res);
    pending_q.push_back(res);
    sent_count++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random backpressure, checked at the rising edge.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          hold = idle_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    pic_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: rdata %02h int_out %0b vector %02h spurious %0b",
                 $time, out_ch.rdata, out_ch.int_out, out_ch.vector, out_ch.spurious);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.rdata !== want.rdata) begin
          errors++;
          $display("%0t rdata: expected %02h actual %02h", $time, want.rdata, out_ch.rdata);
        end
        if (out_ch.int_out !== want.int_out) begin
          errors++;
          $display("%0t int_out: expected %0b actual %0b", $time, want.int_out,
                   out_ch.int_out);
        end
        if (out_ch.vector !== want.vector) begin
          errors++;
          $display("%0t vector: expected %02h actual %02h", $time, want.vector,
                   out_ch.vector);
        end
        if (out_ch.spurious !== want.spurious) begin
          errors++;
          $display("%0t spurious: expected %0b actual %0b", $time, want.spurious,
                   out_ch.spurious);
        end
      end
    end
  end

  task automatic test_after_reset();
    send_item(pic_pkg::KIND_READ, 1'b0, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_READ, 1'b1, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_SAMPLE, 1'b0, 8'h00, 8'hFF);  // all masked, no interrupt
    send_item(pic_pkg::KIND_ACK, 1'b0, 8'h00, 8'h00);     // spurious at base zero
  endtask

  task automatic test_init_sequence();
    send_item(pic_pkg::KIND_WRITE, 1'b0, 8'hFF, 8'h00);   // ICW1: level mode, ICW4 wanted
    send_item(pic_pkg::KIND_WRITE, 1'b0, 8'h0B, 8'h00);   // ignored mid-init
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'hFF, 8'h00);   // ICW2: top base
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'hA5, 8'h00);   // ICW3
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'h00, 8'h00);   // ICW4
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'h7E, 8'h00);   // mask: only IRQ0, IRQ7 open
    send_item(pic_pkg::KIND_READ, 1'b1, 8'h00, 8'h00);
  endtask

  task automatic test_level_priority();
    send_item(pic_pkg::KIND_SAMPLE, 1'b1, 8'h00, 8'hFF);
    send_item(pic_pkg::KIND_ACK, 1'b0, 8'h00, 8'h00);     // IRQ0 into service
    send_item(pic_pkg::KIND_ACK, 1'b1, 8'h00, 8'h00);     // IRQ7 blocked by IRQ0: spurious
    send_item(pic_pkg::KIND_WRITE, 1'b0,
              pic_pkg::OCW3_FLAG | pic_pkg::RR_FLAG | pic_pkg::RIS_FLAG, 8'h00);
    send_item(pic_pkg::KIND_READ, 1'b0, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_WRITE, 1'b0, {pic_pkg::EOI_NONSPEC, 5'b0}, 8'h00);
    send_item(pic_pkg::KIND_ACK, 1'b0, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_READ, 1'b0, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_WRITE, 1'b0, {pic_pkg::EOI_SPEC, 2'b00, 3'd7}, 8'h00);
    send_item(pic_pkg::KIND_WRITE, 1'b0, pic_pkg::OCW3_FLAG | pic_pkg::RR_FLAG, 8'h00);
  endtask

  task automatic test_edge_mode();
    send_item(pic_pkg::KIND_WRITE, 1'b0, pic_pkg::ICW1_FLAG, 8'h00);
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_WRITE, 1'b1, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_SAMPLE, 1'b0, 8'h00, 8'hFF);  // lines already high: no edge
    send_item(pic_pkg::KIND_SAMPLE, 1'b0, 8'h00, 8'h00);
    send_item(pic_pkg::KIND_SAMPLE, 1'b0, 8'h00, 8'h01);  // fresh rising edge on IRQ0
    send_item(pic_pkg::KIND_ACK, 1'b0, 8'h00, 8'h00);
  endtask

  task automatic send_init_noise();
    pic_pkg::kind_t k;
    logic [7:0] d;
    k = pic_pkg::kind_t'($urandom_range(0, 3));
    d = 8'($urandom);
    if (k == pic_pkg::KIND_WRITE) begin
      // command words only, without the ICW1 bit
      send_item(k, 1'b0, d & ~pic_pkg::ICW1_FLAG, 8'($urandom));
    end else begin
      send_item(k, 1'($urandom), d, 8'($urandom));
    end
  endtask

  task automatic send_init_sequence();
    logic [7:0] icw1;
    int nwords;
    icw1 = 8'($urandom);
    icw1 = icw1 | pic_pkg::ICW1_FLAG;
    nwords = ((icw1 & pic_pkg::IC4_FLAG) != 0) ? 3 : 2;
    if ($urandom_range(0, 9) == 0) begin
      nwords = $urandom_range(0, nwords - 1);  // cut short
    end
    send_item(pic_pkg::KIND_WRITE, 1'b0, icw1, 8'($urandom));
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_init_noise();
      end
      send_item(pic_pkg::KIND_WRITE, 1'b1, 8'($urandom), 8'($urandom));
    end
    if ($urandom_range(0, 4) != 0) begin
      send_item(pic_pkg::KIND_WRITE, 1'b1, 8'($urandom & $urandom), 8'($urandom));
    end
  endtask

  task automatic send_random_op();
    int r;
    int bit_sel;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    if (r < 30) begin
      if ($urandom_range(0, 1) == 0) begin
        line_drive = 8'($urandom);
      end else begin
        bit_sel = $urandom_range(0, 7);
        line_drive[bit_sel] = ~line_drive[bit_sel];
      end
      send_item(pic_pkg::KIND_SAMPLE, 1'($urandom), d, line_drive);
    end else if (r < 55) begin
      send_item(pic_pkg::KIND_ACK, 1'($urandom), d, 8'($urandom));
    end else if (r < 65) begin
      send_item(pic_pkg::KIND_READ, 1'($urandom), d, 8'($urandom));
    end else if (r < 75) begin
      case ($urandom_range(0, 2))
        0: d = {pic_pkg::EOI_NONSPEC, 5'b0};
        1: d = {pic_pkg::EOI_SPEC, 2'b00, d[2:0]};
        default: d = {d[7:5], 2'b00, d[2:0]};
      endcase
      send_item(pic_pkg::KIND_WRITE, 1'b0, d, 8'($urandom));
    end else if (r < 83) begin
      send_item(pic_pkg::KIND_WRITE, 1'b0, {d[7:5], 2'b01, d[2:0]}, 8'($urandom));
    end else if (r < 93) begin
      if ($urandom_range(0, 9) < 7) begin
        d = d & 8'($urandom);
      end
      send_item(pic_pkg::KIND_WRITE, 1'b1, d, 8'($urandom));
    end else begin
      send_item(pic_pkg::kind_t'($urandom_range(0, 3)), 1'($urandom), d, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    start = sent_count;
    while (sent_count - start < count) begin
      if ($urandom_range(0, 99) < 6) begin
        send_init_sequence();
      end else begin
        send_random_op();
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_traffic(count);
    idle_on = 1'b1;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = '0;
    in_ch.port_sel  = 1'b0;
    in_ch.wdata     = '0;
    in_ch.irq_lines = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_init_sequence();
    test_level_priority();
    test_edge_mode();
    wait_all_results();  // sender holds off until the pipeline drains
    send_init_sequence();
    test_random_traffic(350);
    test_back_to_back(150);
    wait_all_results();
    test_random_traffic(200);

    wait_all_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pic_pkg.sv
rtl/pic_if.sv
rtl/pic_core.sv
rtl/programmable_interrupt_controller.sv
tb/sv/tb_programmable_interrupt_controller.sv
